[rtl/scmp_pkg.sv]
package scmp_pkg;

  localparam int MAX_WIDTH      = 256;
  localparam int MAX_HEIGHT     = 256;
  localparam int SALIENCY_BITS  = 16;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
  localparam int DIM_BITS       = 9;
  localparam int COST_BITS      = 24;
  localparam int CADDR_BITS     = ROW_BITS + COL_BITS;
  localparam int COST_DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;

  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [COL_BITS-1:0]  col_t;
  typedef logic [ROW_BITS-1:0]  row_t;
  typedef logic [DIM_BITS-1:0]  dim_t;
  typedef logic [COST_BITS-1:0] cost_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_FETCH,
    ST_LD_CALC,
    ST_SCAN,
    ST_SCAN_END,
    ST_WALK_START,
    ST_WK_CENTER,
    ST_WK_LEFT,
    ST_WK_RIGHT,
    ST_WK_DECIDE,
    ST_RD_RESP
  } state_t;

endpackage

[rtl/scmp_req_if.sv]
interface scmp_req_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [scmp_pkg::SALIENCY_BITS-1:0]  saliency;
  logic [scmp_pkg::ROW_BITS-1:0]       row_select;

  modport source (output valid, output operation, output saliency, output row_select,
                  input ready);
  modport sink   (input valid, input operation, input saliency, input row_select,
                  output ready);
endinterface

[rtl/scmp_rsp_if.sv]
interface scmp_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [scmp_pkg::COL_BITS-1:0]   seam_column;
  logic [scmp_pkg::COST_BITS-1:0]  total_cost;
  logic                            seam_ready;

  modport source (output valid, output seam_column, output total_cost, output seam_ready,
                  input ready);
  modport sink   (input valid, input seam_column, input total_cost, input seam_ready,
                  output ready);
endinterface

[rtl/seam_carving_min_path.sv]
// Vertical seam finder for seam carving. Load requests deliver saliency values in row-major
// order for an image of image_width by image_height pixels, and each pixel's accumulated cost
// (saliency plus the least of the up to three costs above it, saturating at 24 bits) is
// written to a single-port-read cost memory. A load passes through ST_LD_CALC, and at the first
// column of every row below the top through ST_LD_FETCH before it, because the cost memory
// gives one read per cycle. After the last pixel the block scans the bottom row and then
// walks upward, and no request is accepted until the walk is done. A read request returns
// the seam column of the selected row with seam_ready set once a seam is complete. Writing
// either configuration register restarts loading at the first pixel.
module seam_carving_min_path (
  input  logic                                 clk,
  input  logic                                 rst,
  scmp_req_if.sink                             req,
  scmp_rsp_if.source                           rsp,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [scmp_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [scmp_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [scmp_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  scmp_pkg::state_t state, state_next;

  scmp_pkg::dim_t  width_reg, height_reg, w_eff, h_eff;
  scmp_pkg::col_t  last_col;
  scmp_pkg::row_t  last_row;

  scmp_pkg::row_t  load_row, row_above;
  scmp_pkg::col_t  load_col;
  logic [scmp_pkg::SALIENCY_BITS-1:0] sal_q;
  scmp_pkg::cost_t win_left, win_center;
  logic            seam_valid;
  scmp_pkg::cost_t best_cost;
  scmp_pkg::col_t  best_col, scan_col, pend_col;
  logic            pend_v;
  scmp_pkg::row_t  walk_row;
  scmp_pkg::col_t  walk_col, walk_next;
  logic            sel_ok;

  logic            out_valid;
  scmp_pkg::col_t  out_column;
  scmp_pkg::cost_t out_cost;
  logic            out_ready_flag;

  logic                             c_we, c_re;
  logic [scmp_pkg::CADDR_BITS-1:0]  c_waddr, c_raddr;
  scmp_pkg::cost_t                  c_wdata, c_rdata;
  logic                             s_we, s_re;
  scmp_pkg::row_t                   s_waddr, s_raddr;
  scmp_pkg::col_t                   s_wdata, s_rdata;

  logic            req_fire, cfg_wr, last_pixel, has_left, has_right, take_best, out_load;
  scmp_pkg::cost_t up_min, cost_sat;
  logic [scmp_pkg::COST_BITS:0] cost_sum;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign req.ready = (state == scmp_pkg::ST_IDLE);
  assign req_fire = req.valid && req.ready;
  assign out_load = (state == scmp_pkg::ST_RD_RESP) && (!out_valid || rsp.ready);

  assign rsp.valid       = out_valid;
  assign rsp.seam_column = out_column;
  assign rsp.total_cost  = out_cost;
  assign rsp.seam_ready  = out_ready_flag;

  always_comb begin
    if (paddr[2] == scmp_pkg::REG_WIDTH) begin
      prdata = scmp_pkg::APB_DATA_BITS'(width_reg);
    end else begin
      prdata = scmp_pkg::APB_DATA_BITS'(height_reg);
    end
  end

  always_comb begin
    if (width_reg < scmp_pkg::DIM_BITS'(2)) begin
      w_eff = scmp_pkg::DIM_BITS'(2);
    end else if (width_reg > scmp_pkg::DIM_BITS'(scmp_pkg::MAX_WIDTH)) begin
      w_eff = scmp_pkg::DIM_BITS'(scmp_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_reg;
    end
    if (height_reg < scmp_pkg::DIM_BITS'(1)) begin
      h_eff = scmp_pkg::DIM_BITS'(1);
    end else if (height_reg > scmp_pkg::DIM_BITS'(scmp_pkg::MAX_HEIGHT)) begin
      h_eff = scmp_pkg::DIM_BITS'(scmp_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_reg;
    end
  end

  assign last_col   = scmp_pkg::COL_BITS'(w_eff - scmp_pkg::DIM_BITS'(1));
  assign last_row   = scmp_pkg::ROW_BITS'(h_eff - scmp_pkg::DIM_BITS'(1));
  assign row_above  = load_row - scmp_pkg::ROW_BITS'(1);
  assign last_pixel = (load_col == last_col) && (load_row == last_row);
  assign has_left   = (load_col != '0);
  assign has_right  = (load_col != last_col);

  // The window holds the costs above the current column on the left and in the center;
  // the right one arrives from the cost memory in the calculation cycle.
  always_comb begin
    up_min = win_center;
    if (has_left && (win_left < up_min)) begin
      up_min = win_left;
    end
    if (has_right && (c_rdata < up_min)) begin
      up_min = c_rdata;
    end
    if (load_row == '0) begin
      cost_sum = (scmp_pkg::COST_BITS + 1)'(sal_q);
    end else begin
      cost_sum = (scmp_pkg::COST_BITS + 1)'(sal_q) + (scmp_pkg::COST_BITS + 1)'(up_min);
    end
    cost_sat = cost_sum[scmp_pkg::COST_BITS] ? scmp_pkg::COST_MAX
                                              : cost_sum[scmp_pkg::COST_BITS-1:0];
  end

  always_comb begin
    walk_next = walk_col;
    if (walk_col == '0) begin
      if (c_rdata < win_center) begin
        walk_next = scmp_pkg::COL_BITS'(1);
      end
    end else if (walk_col == last_col) begin
      if (win_left < win_center) begin
        walk_next = walk_col - scmp_pkg::COL_BITS'(1);
      end
    end else begin
      if ((c_rdata < win_center) && (c_rdata < win_left)) begin
        walk_next = walk_col + scmp_pkg::COL_BITS'(1);
      end else if ((win_left < win_center) && (win_left < c_rdata)) begin
        walk_next = walk_col - scmp_pkg::COL_BITS'(1);
      end
    end
  end

  assign take_best = pend_v && ((pend_col == '0) || (c_rdata < best_cost));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scmp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    c_we    = 1'b0;
    c_waddr = {load_row, load_col};
    c_wdata = cost_sat;
    c_re    = 1'b0;
    c_raddr = {load_row, load_col};
    s_we    = 1'b0;
    s_waddr = walk_row;
    s_wdata = walk_next;
    s_re    = 1'b0;
    s_raddr = req.row_select;
    case (state)
      scmp_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req.operation == scmp_pkg::OP_READ) begin
            s_re       = 1'b1;
            state_next = scmp_pkg::ST_RD_RESP;
          end else if (load_row == '0) begin
            state_next = scmp_pkg::ST_LD_CALC;
          end else if (load_col == '0) begin
            c_re       = 1'b1;
            c_raddr    = {row_above, scmp_pkg::COL_BITS'(0)};
            state_next = scmp_pkg::ST_LD_FETCH;
          end else if (load_col != last_col) begin
            c_re       = 1'b1;
            c_raddr    = {row_above, load_col + scmp_pkg::COL_BITS'(1)};
            state_next = scmp_pkg::ST_LD_CALC;
          end else begin
            state_next = scmp_pkg::ST_LD_CALC;
          end
        end
      end
      scmp_pkg::ST_LD_FETCH: begin
        c_re       = 1'b1;
        c_raddr    = {row_above, scmp_pkg::COL_BITS'(1)};
        state_next = scmp_pkg::ST_LD_CALC;
      end
      scmp_pkg::ST_LD_CALC: begin
        c_we       = 1'b1;
        state_next = last_pixel ? scmp_pkg::ST_SCAN : scmp_pkg::ST_IDLE;
      end
      scmp_pkg::ST_SCAN: begin
        c_re    = 1'b1;
        c_raddr = {last_row, scan_col};
        if (scan_col == last_col) begin
          state_next = scmp_pkg::ST_SCAN_END;
        end
      end
      scmp_pkg::ST_SCAN_END: begin
        state_next = scmp_pkg::ST_WALK_START;
      end
      scmp_pkg::ST_WALK_START: begin
        s_we       = 1'b1;
        s_waddr    = last_row;
        s_wdata    = best_col;
        state_next = (last_row == '0) ? scmp_pkg::ST_IDLE : scmp_pkg::ST_WK_CENTER;
      end
      scmp_pkg::ST_WK_CENTER: begin
        c_re       = 1'b1;
        c_raddr    = {walk_row, walk_col};
        state_next = scmp_pkg::ST_WK_LEFT;
      end
      scmp_pkg::ST_WK_LEFT: begin
        c_re       = 1'b1;
        c_raddr    = {walk_row, (walk_col == '0) ? walk_col
                                                 : walk_col - scmp_pkg::COL_BITS'(1)};
        state_next = scmp_pkg::ST_WK_RIGHT;
      end
      scmp_pkg::ST_WK_RIGHT: begin
        c_re       = 1'b1;
        c_raddr    = {walk_row, (walk_col == last_col) ? walk_col
                                                       : walk_col + scmp_pkg::COL_BITS'(1)};
        state_next = scmp_pkg::ST_WK_DECIDE;
      end
      scmp_pkg::ST_WK_DECIDE: begin
        s_we       = 1'b1;
        state_next = (walk_row == '0) ? scmp_pkg::ST_IDLE : scmp_pkg::ST_WK_CENTER;
      end
      scmp_pkg::ST_RD_RESP: begin
        if (out_load) begin
          state_next = scmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scmp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= scmp_pkg::DIM_BITS'(scmp_pkg::MAX_WIDTH);
      height_reg <= scmp_pkg::DIM_BITS'(scmp_pkg::MAX_HEIGHT);
      load_row   <= '0;
      load_col   <= '0;
      seam_valid <= 1'b0;
      best_cost  <= '0;
      pend_v     <= 1'b0;
    end else begin
      case (state)
        scmp_pkg::ST_IDLE: begin
          if (req_fire && (req.operation == scmp_pkg::OP_LOAD)) begin
            seam_valid <= 1'b0;
          end
        end
        scmp_pkg::ST_LD_CALC: begin
          if (load_col == last_col) begin
            load_col <= '0;
            if (load_row == last_row) begin
              load_row <= '0;
              pend_v   <= 1'b0;
            end else begin
              load_row <= load_row + scmp_pkg::ROW_BITS'(1);
            end
          end else begin
            load_col <= load_col + scmp_pkg::COL_BITS'(1);
          end
        end
        scmp_pkg::ST_SCAN: begin
          pend_v <= 1'b1;
          if (take_best) begin
            best_cost <= c_rdata;
          end
        end
        scmp_pkg::ST_SCAN_END: begin
          pend_v <= 1'b0;
          if (take_best) begin
            best_cost <= c_rdata;
          end
        end
        scmp_pkg::ST_WALK_START: begin
          if (last_row == '0) begin
            seam_valid <= 1'b1;
          end
        end
        scmp_pkg::ST_WK_DECIDE: begin
          if (walk_row == '0) begin
            seam_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (cfg_wr) begin
        if (paddr[2] == scmp_pkg::REG_WIDTH) begin
          width_reg <= pwdata[scmp_pkg::DIM_BITS-1:0];
        end else begin
          height_reg <= pwdata[scmp_pkg::DIM_BITS-1:0];
        end
        load_row   <= '0;
        load_col   <= '0;
        seam_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      scmp_pkg::ST_IDLE: begin
        if (req_fire) begin
          sal_q  <= req.saliency;
          sel_ok <= seam_valid && (scmp_pkg::DIM_BITS'(req.row_select) < h_eff);
        end
      end
      scmp_pkg::ST_LD_FETCH: begin
        win_center <= c_rdata;
      end
      scmp_pkg::ST_LD_CALC: begin
        win_left   <= win_center;
        win_center <= c_rdata;
        scan_col   <= '0;
      end
      scmp_pkg::ST_SCAN: begin
        pend_col <= scan_col;
        scan_col <= scan_col + scmp_pkg::COL_BITS'(1);
        if (take_best) begin
          best_col <= pend_col;
        end
      end
      scmp_pkg::ST_SCAN_END: begin
        if (take_best) begin
          best_col <= pend_col;
        end
      end
      scmp_pkg::ST_WALK_START: begin
        walk_col <= best_col;
        walk_row <= last_row - scmp_pkg::ROW_BITS'(1);
      end
      scmp_pkg::ST_WK_LEFT: begin
        win_center <= c_rdata;
      end
      scmp_pkg::ST_WK_RIGHT: begin
        win_left <= c_rdata;
      end
      scmp_pkg::ST_WK_DECIDE: begin
        walk_col <= walk_next;
        walk_row <= walk_row - scmp_pkg::ROW_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ready_flag <= sel_ok;
      out_column     <= sel_ok ? s_rdata : '0;
      out_cost       <= sel_ok ? best_cost : '0;
    end
  end

  scmp_ram #(
    .WIDTH (scmp_pkg::COST_BITS),
    .DEPTH (scmp_pkg::COST_DEPTH)
  ) u_cost_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  scmp_ram #(
    .WIDTH (scmp_pkg::COL_BITS),
    .DEPTH (scmp_pkg::MAX_HEIGHT)
  ) u_seam_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

endmodule

[rtl/scmp_ram.sv]
module scmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/scmp_checker.sv]
module scmp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            req_operation,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [scmp_pkg::COL_BITS-1:0]   rsp_seam_column,
  input logic [scmp_pkg::COST_BITS-1:0]  rsp_total_cost,
  input logic                            rsp_seam_ready
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seam_column)
      && $stable(rsp_total_cost) && $stable(rsp_seam_ready))
    else $error("response changed while stalled");

  a_rsp_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready && req_operation == scmp_pkg::OP_READ, 2))
    else $error("response without a read request two cycles earlier");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_seam_ready |-> rsp_seam_column == '0 && rsp_total_cost == '0)
    else $error("response without a seam carries nonzero fields");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while the previous one is still in progress");

endmodule

bind seam_carving_min_path scmp_checker u_scmp_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_operation   (req.operation),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_seam_column (rsp.seam_column),
  .rsp_total_cost  (rsp.total_cost),
  .rsp_seam_ready  (rsp.seam_ready)
);

[tb/sv/tb_seam_carving_min_path.sv]
module tb_seam_carving_min_path;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic [scmp_pkg::SALIENCY_BITS-1:0] saliency_t;

  typedef struct packed {
    scmp_pkg::col_t  column;
    scmp_pkg::cost_t cost;
    logic            ready;
  } seam_answer_t;

  logic                                clk;
  logic                                rst;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [scmp_pkg::APB_ADDR_BITS-1:0]  paddr;
  logic [scmp_pkg::APB_DATA_BITS-1:0]  pwdata;
  logic [scmp_pkg::APB_DATA_BITS-1:0]  prdata;
  logic                                pready;

  scmp_req_if req_bus();
  scmp_rsp_if rsp_bus();

  seam_carving_min_path dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scmp_pkg::cost_t cost_mem [scmp_pkg::COST_DEPTH];
  scmp_pkg::col_t  seam_mem [scmp_pkg::MAX_HEIGHT];
  int unsigned     ld_row;
  int unsigned     ld_col;
  scmp_pkg::cost_t min_cost;
  bit              seam_done;
  scmp_pkg::dim_t  cfg_width;
  scmp_pkg::dim_t  cfg_height;

  seam_answer_t seam_answers[$];
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           rsp_hold = 0;
  bit           steady = 1'b0;
  int unsigned  items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned width_used();
    if (32'(cfg_width) < 2) return 2;
    if (32'(cfg_width) > scmp_pkg::MAX_WIDTH) return scmp_pkg::MAX_WIDTH;
    return 32'(cfg_width);
  endfunction

  function automatic int unsigned height_used();
    if (32'(cfg_height) < 1) return 1;
    if (32'(cfg_height) > scmp_pkg::MAX_HEIGHT) return scmp_pkg::MAX_HEIGHT;
    return 32'(cfg_height);
  endfunction

  function automatic scmp_pkg::cost_t cost_at(int unsigned col, int unsigned row);
    return cost_mem[{scmp_pkg::row_t'(row), scmp_pkg::col_t'(col)}];
  endfunction

  function automatic void locate_seam(int unsigned w, int unsigned h);
    int unsigned     col;
    int unsigned     c;
    int unsigned     r;
    scmp_pkg::cost_t best;
    scmp_pkg::cost_t centre;
    scmp_pkg::cost_t left;
    scmp_pkg::cost_t right;
    col = 0;
    best = cost_at(0, h - 1);
    for (c = 1; c < w; c++) begin
      if (cost_at(c, h - 1) < best) begin
        best = cost_at(c, h - 1);
        col = c;
      end
    end
    min_cost = best;
    seam_mem[scmp_pkg::row_t'(h - 1)] = scmp_pkg::col_t'(col);
    for (r = h - 1; r > 0; r--) begin
      centre = cost_at(col, r - 1);
      if (col == 0) begin
        if (cost_at(1, r - 1) < centre) col = 1;
      end else if (col == w - 1) begin
        if (cost_at(col - 1, r - 1) < centre) col = col - 1;
      end else begin
        left = cost_at(col - 1, r - 1);
        right = cost_at(col + 1, r - 1);
        if (right < centre && right < left) col = col + 1;
        else if (left < centre && left < right) col = col - 1;
      end
      seam_mem[scmp_pkg::row_t'(r - 1)] = scmp_pkg::col_t'(col);
    end
    seam_done = 1'b1;
  endfunction

  function automatic void accumulate_pixel(saliency_t sal);
    int unsigned                   w;
    int unsigned                   h;
    int unsigned                   col;
    int unsigned                   row;
    logic [scmp_pkg::COST_BITS:0]  total;
    scmp_pkg::cost_t               above;
    w = width_used();
    h = height_used();
    if (ld_col >= w || ld_row >= h) begin
      ld_col = 0;
      ld_row = 0;
    end
    seam_done = 1'b0;
    col = ld_col;
    row = ld_row;
    total = (scmp_pkg::COST_BITS + 1)'(sal);
    if (row > 0) begin
      above = cost_at(col, row - 1);
      if (col > 0 && cost_at(col - 1, row - 1) < above) begin
        above = cost_at(col - 1, row - 1);
      end
      if (col + 1 < w && cost_at(col + 1, row - 1) < above) begin
        above = cost_at(col + 1, row - 1);
      end
      total = total + (scmp_pkg::COST_BITS + 1)'(above);
    end
    if (total > {1'b0, scmp_pkg::COST_MAX}) total = {1'b0, scmp_pkg::COST_MAX};
    cost_mem[{scmp_pkg::row_t'(row), scmp_pkg::col_t'(col)}] =
      total[scmp_pkg::COST_BITS-1:0];
    if (col + 1 < w) begin
      ld_col = col + 1;
    end else begin
      ld_col = 0;
      if (row + 1 < h) begin
        ld_row = row + 1;
      end else begin
        ld_row = 0;
        locate_seam(w, h);
      end
    end
  endfunction

  function automatic seam_answer_t answer_read(scmp_pkg::row_t row);
    seam_answer_t a;
    a = '0;
    if (seam_done && 32'(row) < height_used()) begin
      a.column = seam_mem[row];
      a.cost = min_cost;
      a.ready = 1'b1;
    end
    return a;
  endfunction

  function automatic int unsigned pick_saliency(int unsigned mode);
    case (mode)
      0: return $urandom_range(3);
      1: return $urandom_range(255);
      2: return $urandom_range(65535, 65280);
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic send_request(input logic op, input saliency_t sal,
                              input scmp_pkg::row_t row);
    while (!steady && $urandom_range(99) < 9) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.operation <= op;
    req_bus.saliency <= sal;
    req_bus.row_select <= row;
    do @(posedge clk); while (!req_bus.ready);
    items_sent++;
    if (op == scmp_pkg::OP_LOAD) accumulate_pixel(sal);
    else seam_answers.push_back(answer_read(row));
  endtask

  task automatic load_pixel(input int unsigned sal);
    send_request(scmp_pkg::OP_LOAD, saliency_t'(sal), scmp_pkg::row_t'($urandom));
  endtask

  task automatic read_row(input int unsigned row);
    send_request(scmp_pkg::OP_READ, saliency_t'($urandom), scmp_pkg::row_t'(row));
  endtask

  task automatic load_image(input int unsigned count, input int unsigned mode, input bit noisy);
    repeat (count) begin
      if (noisy && $urandom_range(19) == 0) read_row($urandom_range(255));
      load_pixel(pick_saliency(mode));
    end
  endtask

  task automatic await_answers();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (seam_answers.size() != 0);
  endtask

  // The seam walk produces no result, so its length is waited out after the last read.
  task automatic settle();
    await_answers();
    repeat (width_used() + 4 * height_used() + 64) @(posedge clk);
  endtask

  task automatic write_register(input logic index, input int unsigned value);
    logic [scmp_pkg::APB_DATA_BITS-1:0] data;
    scmp_pkg::dim_t                     code;
    settle();
    code = scmp_pkg::DIM_BITS'(value);
    data = $urandom;
    data[scmp_pkg::DIM_BITS-1:0] = code;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == scmp_pkg::REG_WIDTH) cfg_width = code;
    else cfg_height = code;
    ld_row = 0;
    ld_col = 0;
    seam_done = 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== scmp_pkg::APB_DATA_BITS'(code)) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("register read mismatch: expected %0d, got %0d", code, prdata);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input int unsigned width_value, input int unsigned height_value);
    write_register(scmp_pkg::REG_WIDTH, width_value);
    write_register(scmp_pkg::REG_HEIGHT, height_value);
  endtask

  task automatic test_read_before_image();
    read_row(0);
    read_row(255);
  endtask

  task automatic test_smallest_image();
    configure(2, 1);
    load_pixel(5);
    load_pixel(3);
    read_row(0);
    read_row(1);
    read_row(255);
    load_pixel(4);
    load_pixel(4);
    read_row(0);
    load_pixel(65535);
    load_pixel(65535);
    read_row(0);
  endtask

  task automatic test_backtrack_ties();
    configure(2, 2);
    load_pixel(7); load_pixel(7); load_pixel(0); load_pixel(1);
    read_row(0);
    load_pixel(7); load_pixel(6); load_pixel(0); load_pixel(1);
    read_row(0);
    load_pixel(6); load_pixel(7); load_pixel(1); load_pixel(0);
    read_row(0);
    read_row(1);
    configure(3, 2);
    load_pixel(5); load_pixel(3); load_pixel(3); load_pixel(9); load_pixel(0); load_pixel(9);
    read_row(0);
    load_pixel(4); load_pixel(5); load_pixel(1); load_pixel(9); load_pixel(0); load_pixel(9);
    read_row(0);
    load_pixel(1); load_pixel(5); load_pixel(4); load_pixel(9); load_pixel(0); load_pixel(9);
    read_row(0);
    load_pixel(2); load_pixel(4); load_pixel(2); load_pixel(9); load_pixel(0); load_pixel(9);
    read_row(0);
  endtask

  task automatic test_restart_and_reload();
    configure(3, 2);
    load_image(3, 1, 1'b0);
    read_row(0);
    write_register(scmp_pkg::REG_HEIGHT, 2);
    load_image(6, 1, 1'b0);
    read_row(1);
    load_pixel(pick_saliency(3));
    read_row(0);
    load_image(5, 0, 1'b0);
    read_row(0);
    read_row(1);
  endtask

  task automatic test_dimension_extremes();
    configure(511, 0);
    load_image(256, 3, 1'b0);
    read_row(0);
    read_row(1);
    read_row(200);
    configure(1, 24);
    load_image(48, 2, 1'b0);
    read_row(0);
    read_row(23);
    read_row(24);
    configure(3, 300);
    load_image(30, 1, 1'b0);
    read_row(0);
    read_row(255);
  endtask

  task automatic test_backpressure();
    configure(4, 3);
    load_image(12, 1, 1'b0);
    rsp_hold = 400;
    repeat (40) read_row($urandom_range(3));
    await_answers();
    read_row(2);
  endtask

  task automatic test_random_images();
    int unsigned stop_at;
    int unsigned img;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    int unsigned count;
    int unsigned w_code;
    int unsigned h_code;
    stop_at = items_sent + 150;
    img = 0;
    while (items_sent < stop_at) begin
      steady = (img >= 2 && img < 5);
      if (img == 0 || $urandom_range(3) != 0) begin
        pick = $urandom_range(19);
        if (pick < 15) begin
          w = $urandom_range(8, 2);
          h = $urandom_range(8, 1);
        end else if (pick < 19) begin
          w = $urandom_range(24, 9);
          h = $urandom_range(6, 1);
        end else begin
          w = $urandom_range(64, 25);
          h = $urandom_range(2, 1);
        end
        w_code = w;
        h_code = h;
        if (w == 2 && $urandom_range(1) == 1) w_code = $urandom_range(1);
        if (h == 1 && $urandom_range(1) == 1) h_code = 0;
        configure(w_code, h_code);
      end
      w = width_used();
      h = height_used();
      count = w * h;
      if ($urandom_range(9) == 0) count = $urandom_range(count, 1);
      load_image(count, $urandom_range(3), 1'b1);
      repeat ($urandom_range(6, 1)) begin
        read_row($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(h - 1));
      end
      img++;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_bus.valid <= 1'b0;
    req_bus.operation <= scmp_pkg::OP_LOAD;
    req_bus.saliency <= '0;
    req_bus.row_select <= '0;
    cfg_width = scmp_pkg::DIM_BITS'(scmp_pkg::MAX_WIDTH);
    cfg_height = scmp_pkg::DIM_BITS'(scmp_pkg::MAX_HEIGHT);
    ld_row = 0;
    ld_col = 0;
    min_cost = '0;
    seam_done = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_read_before_image();
    test_smallest_image();
    test_backtrack_ties();
    test_restart_and_reload();
    test_dimension_extremes();
    test_backpressure();
    test_random_images();
    settle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold != 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (rsp_hold) @(posedge clk);
        rsp_hold = 0;
      end else begin
        rsp_bus.ready <= steady || ($urandom_range(99) >= 9);
      end
    end
  end

  always @(posedge clk) begin : check_answers
    seam_answer_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (seam_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("seam read result with no request pending: col %0d cost %0d ready %0d",
                   rsp_bus.seam_column, rsp_bus.total_cost, rsp_bus.seam_ready);
        end
      end else begin
        want = seam_answers.pop_front();
        if (rsp_bus.seam_column !== want.column || rsp_bus.total_cost !== want.cost ||
            rsp_bus.seam_ready !== want.ready) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("seam read mismatch: expected col %0d cost %0d ready %0d,",
                     want.column, want.cost, want.ready);
            $display("  got col %0d cost %0d ready %0d",
                     rsp_bus.seam_column, rsp_bus.total_cost, rsp_bus.seam_ready);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
